/* sv/nlv_pkg.sv */
// Package with character codes and character classes for the numeric literal validator.
`timescale 1ns / 1ps

package nlv_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned TdataW = 8;

  localparam logic [CharW-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CharW-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CharW-1:0] CHAR_E_LO  = 8'h65;
  localparam logic [CharW-1:0] CHAR_E_UP  = 8'h45;
  localparam logic [CharW-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CharW-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CharW-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;

  localparam logic MODE_FLOAT = 1'b0;
  localparam logic MODE_INT   = 1'b1;

  function automatic logic is_ws(input logic [CharW-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_dig(input logic [CharW-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_sign(input logic [CharW-1:0] c);
    return (c == CHAR_PLUS) || (c == CHAR_MINUS);
  endfunction

  function automatic logic is_exp(input logic [CharW-1:0] c);
    return (c == CHAR_E_LO) || (c == CHAR_E_UP);
  endfunction

endpackage

/* sv/numeric_literal_validator_core.sv */
// Numeric literal validator: byte-stream parser that gives one verdict per terminated string.
`timescale 1ns / 1ps

// Takes one character per cycle on the input stream while in_tready is high and
// returns one verdict (tdata bit 0: 1 = valid) for each zero terminator byte, in
// the cycle after that byte is transferred; other bytes give no output. The rate
// is one byte per cycle while the output is not stalled, set by the single
// parse-phase register that a small next-state function updates on each transfer.
// The verdict waits in an output register; input is taken whenever that register
// is empty or being drained. cfg_wr_data selects the grammar (0 float, 1 integer);
// it is the user's duty to write it only while no string is in progress; the block has no check for it.
module numeric_literal_validator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [nlv_pkg::TdataW-1:0]       in_tdata,   // [7:0] char_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [nlv_pkg::TdataW-1:0]       out_tdata   // [0] is_valid, [7:1] zero
);

  typedef enum logic [3:0] {
    PH_LEAD     = 4'd0,
    PH_SIGN     = 4'd1,
    PH_INTDIG   = 4'd2,
    PH_DOTAFTER = 4'd3,
    PH_DOTFIRST = 4'd4,
    PH_FRACDIG  = 4'd5,
    PH_EXP      = 4'd6,
    PH_EXPSIGN  = 4'd7,
    PH_EXPDIG   = 4'd8,
    PH_ACCEPT   = 4'd9,
    PH_REJECT   = 4'd10
  } phase_t;

  logic                         mode_r;
  phase_t                       phase_r;
  phase_t                       step_phase;
  phase_t                       phase_nxt;
  logic                         out_tvalid_r;
  logic                         out_tvalid_nxt;
  logic                         is_valid_r;
  logic                         is_valid_nxt;
  logic                         in_xfer;
  logic                         term;
  logic                         int_mode;
  logic [nlv_pkg::CharW-1:0]    c;
  logic                         ok;

  assign c        = in_tdata[nlv_pkg::CharW-1:0];
  assign int_mode = (mode_r == nlv_pkg::MODE_INT);
  assign term     = (c == nlv_pkg::CHAR_NUL);
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_xfer  = in_tvalid && in_tready;

  always_comb begin
    step_phase = PH_REJECT;
    case (phase_r)
      PH_LEAD: begin
        if (nlv_pkg::is_ws(c)) step_phase = PH_LEAD;
        else if (nlv_pkg::is_sign(c)) step_phase = PH_SIGN;
        else if (nlv_pkg::is_dig(c)) step_phase = PH_INTDIG;
        else if (c == nlv_pkg::CHAR_DOT && !int_mode) step_phase = PH_DOTFIRST;
      end
      PH_SIGN: begin
        if (nlv_pkg::is_dig(c)) step_phase = PH_INTDIG;
        else if (c == nlv_pkg::CHAR_DOT && !int_mode) step_phase = PH_DOTFIRST;
      end
      PH_INTDIG: begin
        if (nlv_pkg::is_dig(c)) step_phase = PH_INTDIG;
        else if (c == nlv_pkg::CHAR_DOT) step_phase = PH_DOTAFTER;
        else if (nlv_pkg::is_ws(c)) step_phase = PH_ACCEPT;
        else if (nlv_pkg::is_exp(c) && !int_mode) step_phase = PH_EXP;
      end
      PH_DOTAFTER: begin
        if (nlv_pkg::is_ws(c)) step_phase = PH_ACCEPT;
        else if (int_mode) step_phase = PH_REJECT;
        else if (nlv_pkg::is_dig(c)) step_phase = PH_FRACDIG;
        else if (nlv_pkg::is_exp(c)) step_phase = PH_EXP;
      end
      PH_DOTFIRST: begin
        if (nlv_pkg::is_dig(c)) step_phase = PH_FRACDIG;
      end
      PH_FRACDIG: begin
        if (nlv_pkg::is_dig(c)) step_phase = PH_FRACDIG;
        else if (nlv_pkg::is_exp(c)) step_phase = PH_EXP;
        else if (nlv_pkg::is_ws(c)) step_phase = PH_ACCEPT;
      end
      PH_EXP: begin
        if (nlv_pkg::is_sign(c)) step_phase = PH_EXPSIGN;
        else if (nlv_pkg::is_dig(c)) step_phase = PH_EXPDIG;
      end
      PH_EXPSIGN: begin
        if (nlv_pkg::is_dig(c)) step_phase = PH_EXPDIG;
      end
      PH_EXPDIG: begin
        if (nlv_pkg::is_dig(c)) step_phase = PH_EXPDIG;
        else if (nlv_pkg::is_ws(c)) step_phase = PH_ACCEPT;
      end
      PH_ACCEPT: step_phase = PH_ACCEPT;
      default:   step_phase = PH_REJECT;
    endcase
  end

  assign ok = (phase_r == PH_INTDIG) || (phase_r == PH_DOTAFTER) ||
              (phase_r == PH_FRACDIG) || (phase_r == PH_EXPDIG) ||
              (phase_r == PH_ACCEPT);

  always_comb begin
    phase_nxt      = phase_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    is_valid_nxt   = is_valid_r;
    if (in_xfer) begin
      if (term) begin
        phase_nxt      = PH_LEAD;
        out_tvalid_nxt = 1'b1;
        is_valid_nxt   = ok;
      end else begin
        phase_nxt = step_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= nlv_pkg::MODE_FLOAT;
      phase_r      <= PH_LEAD;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      phase_r      <= phase_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    is_valid_r <= is_valid_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(nlv_pkg::TdataW-1){1'b0}}, is_valid_r};

  a_term_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && term |=> out_tvalid_r && phase_r == PH_LEAD)
    else $error("terminator transfer did not produce a verdict");

  a_char_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !term |=> !out_tvalid_r)
    else $error("non-terminator byte produced a verdict");

  a_accept_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !term && phase_r == PH_ACCEPT |=> phase_r == PH_ACCEPT)
    else $error("accepted string left the accept phase before its terminator");

  a_reject_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !term && phase_r == PH_REJECT |=> phase_r == PH_REJECT)
    else $error("rejected string left the reject phase before its terminator");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the numeric literal validator core: directed strings, then random.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BYTES = 500;
  localparam int unsigned PHASE_BYTES  = 50;
  localparam int unsigned DIR_ROWS     = 10;
  localparam int          BY_PREDICTOR = -1;

  typedef enum logic [3:0] {
    LEAD_WS, AFTER_SIGN, INT_DIGITS, DOT_AFTER_INT, DOT_FIRST, FRAC_DIGITS,
    EXP_MARK, EXP_SIGN, EXP_DIGITS, ACCEPTED, REJECTED
  } parse_phase_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic                       cfg_wr_data = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [nlv_pkg::TdataW-1:0] in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [nlv_pkg::TdataW-1:0] out_tdata;

  logic               model_mode = nlv_pkg::MODE_FLOAT;
  parse_phase_t       model_phase = LEAD_WS;
  bit                 verdicts_due[$];
  int                 typed_verdicts[$];
  byte unsigned       text_buf[$];
  bit                 quiet = 1'b0;
  int unsigned        failures = 0;
  int unsigned        cycles = 0;
  bit                 due_verdict;

  // directed strings: grammar, text (terminator appended), verdict or predictor
  logic  dir_mode [DIR_ROWS] = '{nlv_pkg::MODE_FLOAT, nlv_pkg::MODE_FLOAT, nlv_pkg::MODE_FLOAT,
                                 nlv_pkg::MODE_FLOAT, nlv_pkg::MODE_FLOAT, nlv_pkg::MODE_FLOAT,
                                 nlv_pkg::MODE_FLOAT, nlv_pkg::MODE_INT, nlv_pkg::MODE_INT,
                                 nlv_pkg::MODE_INT};
  string dir_text [DIR_ROWS] = '{"", " \011\015", "7", "-.5E9", "\377",
                                 "3 \200", "1.e+", "+9.", ".5", "8x"};
  int    dir_verdict [DIR_ROWS] = '{0, 0, 1, 1, 0, 1, BY_PREDICTOR, 1, 0, BY_PREDICTOR};

  numeric_literal_validator_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit blank_char(input logic [7:0] c);
    return (c == nlv_pkg::CHAR_SPACE) ||
           ((c >= nlv_pkg::CHAR_TAB) && (c <= nlv_pkg::CHAR_CR));
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return (c >= nlv_pkg::CHAR_ZERO) && (c <= nlv_pkg::CHAR_NINE);
  endfunction

  function automatic bit sign_char(input logic [7:0] c);
    return (c == nlv_pkg::CHAR_PLUS) || (c == nlv_pkg::CHAR_MINUS);
  endfunction

  function automatic bit exp_char(input logic [7:0] c);
    return (c == nlv_pkg::CHAR_E_LO) || (c == nlv_pkg::CHAR_E_UP);
  endfunction

  function automatic parse_phase_t advance_phase(input parse_phase_t ph, input logic [7:0] c,
                                                 input logic mode);
    parse_phase_t nxt;
    nxt = REJECTED;
    case (ph)
      LEAD_WS, AFTER_SIGN: begin
        if (ph == LEAD_WS && blank_char(c)) nxt = LEAD_WS;
        else if (ph == LEAD_WS && sign_char(c)) nxt = AFTER_SIGN;
        else if (digit_char(c)) nxt = INT_DIGITS;
        else if (c == nlv_pkg::CHAR_DOT && mode == nlv_pkg::MODE_FLOAT) nxt = DOT_FIRST;
      end
      INT_DIGITS: begin
        if (digit_char(c)) nxt = INT_DIGITS;
        else if (c == nlv_pkg::CHAR_DOT) nxt = DOT_AFTER_INT;
        else if (blank_char(c)) nxt = ACCEPTED;
        else if (exp_char(c) && mode == nlv_pkg::MODE_FLOAT) nxt = EXP_MARK;
      end
      DOT_AFTER_INT: begin
        if (blank_char(c)) nxt = ACCEPTED;
        else if (mode == nlv_pkg::MODE_INT) nxt = REJECTED;
        else if (digit_char(c)) nxt = FRAC_DIGITS;
        else if (exp_char(c)) nxt = EXP_MARK;
      end
      DOT_FIRST: begin
        if (digit_char(c)) nxt = FRAC_DIGITS;
      end
      FRAC_DIGITS: begin
        if (digit_char(c)) nxt = FRAC_DIGITS;
        else if (exp_char(c)) nxt = EXP_MARK;
        else if (blank_char(c)) nxt = ACCEPTED;
      end
      EXP_MARK, EXP_SIGN: begin
        if (ph == EXP_MARK && sign_char(c)) nxt = EXP_SIGN;
        else if (digit_char(c)) nxt = EXP_DIGITS;
      end
      EXP_DIGITS: begin
        if (digit_char(c)) nxt = EXP_DIGITS;
        else if (blank_char(c)) nxt = ACCEPTED;
      end
      ACCEPTED: nxt = ACCEPTED;
      default:  nxt = REJECTED;
    endcase
    return nxt;
  endfunction

  function automatic bit phase_valid(input parse_phase_t ph);
    return (ph == INT_DIGITS) || (ph == DOT_AFTER_INT) || (ph == FRAC_DIGITS) ||
           (ph == EXP_DIGITS) || (ph == ACCEPTED);
  endfunction

  function automatic byte unsigned pick_blank();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? nlv_pkg::CHAR_SPACE : 8'(nlv_pkg::CHAR_TAB + k);
  endfunction

  function automatic byte unsigned pick_digit();
    return 8'(nlv_pkg::CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic byte unsigned pick_sign();
    return $urandom_range(0, 1) ? nlv_pkg::CHAR_PLUS : nlv_pkg::CHAR_MINUS;
  endfunction

  // track the parser on every accepted input transfer
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tdata == nlv_pkg::CHAR_NUL) begin
        if (typed_verdicts.size() != 0 && typed_verdicts[0] != BY_PREDICTOR)
          verdicts_due.push_back(typed_verdicts[0] != 0);
        else
          verdicts_due.push_back(phase_valid(model_phase));
        if (typed_verdicts.size() != 0) void'(typed_verdicts.pop_front());
        model_phase = LEAD_WS;
      end else begin
        model_phase = advance_phase(model_phase, in_tdata, model_mode);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected verdict: is_valid actual %0d", out_tdata[0]);
        failures++;
      end else begin
        due_verdict = verdicts_due.pop_front();
        if (out_tdata[0] !== due_verdict) begin
          $error("is_valid mismatch: expected %0d actual %0d", due_verdict, out_tdata[0]);
          failures++;
        end
        if (out_tdata[nlv_pkg::TdataW-1:1] !== '0) begin
          $error("out_tdata pad mismatch: expected 0 actual %0h",
                 out_tdata[nlv_pkg::TdataW-1:1]);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // random stalls on the result side
  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_byte(input byte unsigned c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_text(input int verdict, inout int unsigned sent);
    typed_verdicts.push_back(verdict);
    foreach (text_buf[i]) send_byte(text_buf[i]);
    send_byte(nlv_pkg::CHAR_NUL);
    sent += text_buf.size() + 1;
  endtask

  // hold input idle until every verdict has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    model_mode = mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly well-formed literals with random content, some broken, some noise
  task automatic build_literal(input logic mode);
    int unsigned form;
    int unsigned k;
    text_buf.delete();
    form = $urandom_range(0, 9);
    if (form == 0) begin
      repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom_range(1, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
    if ($urandom_range(0, 1)) text_buf.push_back(pick_sign());
    if (mode == nlv_pkg::MODE_FLOAT && $urandom_range(0, 4) == 0) begin
      text_buf.push_back(nlv_pkg::CHAR_DOT);
      repeat ($urandom_range(1, 3)) text_buf.push_back(pick_digit());
    end else begin
      repeat ($urandom_range(1, 4)) text_buf.push_back(pick_digit());
      if ($urandom_range(0, 2) == 0) begin
        text_buf.push_back(nlv_pkg::CHAR_DOT);
        if (mode == nlv_pkg::MODE_FLOAT)
          repeat ($urandom_range(0, 3)) text_buf.push_back(pick_digit());
      end
    end
    if (mode == nlv_pkg::MODE_FLOAT && $urandom_range(0, 2) == 0) begin
      text_buf.push_back($urandom_range(0, 1) ? nlv_pkg::CHAR_E_LO : nlv_pkg::CHAR_E_UP);
      if ($urandom_range(0, 1)) text_buf.push_back(pick_sign());
      repeat ($urandom_range(1, 3)) text_buf.push_back(pick_digit());
    end
    if ($urandom_range(0, 3) == 0) begin
      text_buf.push_back(pick_blank());
      repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
    end
    if (form <= 3 && text_buf.size() != 0) begin
      k = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 2))
        0:       text_buf[k] = 8'($urandom_range(1, 255));
        1:       void'(text_buf.pop_back());
        default: text_buf.insert(k, ($urandom_range(0, 1) ? nlv_pkg::CHAR_DOT :
                                     ($urandom_range(0, 1) ? nlv_pkg::CHAR_E_LO :
                                                             nlv_pkg::CHAR_PLUS)));
      endcase
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_start;
    int unsigned phase_no;
    logic        mode_now;
    string       s;
    sent = 0;
    phase_no = 0;
    mode_now = nlv_pkg::MODE_FLOAT;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_mode[r] != mode_now) begin
        settle();
        write_mode(dir_mode[r]);
        mode_now = dir_mode[r];
      end
      s = dir_text[r];
      text_buf.delete();
      for (int j = 0; j < s.len(); j++) text_buf.push_back(s[j]);
      send_text(dir_verdict[r], sent);
    end

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      settle();
      quiet = (phase_no % 4 == 3);
      mode_now = (phase_no % 2 == 0) ? nlv_pkg::MODE_FLOAT : nlv_pkg::MODE_INT;
      write_mode(mode_now);
      phase_start = sent;
      while (sent - phase_start < PHASE_BYTES) begin
        build_literal(($urandom_range(0, 4) == 0) ? ~mode_now : mode_now);
        send_text(BY_PREDICTOR, sent);
      end
      phase_no++;
    end

    settle();
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
